FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication within the same cycle.
`define SLA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Implication in the next cycle.
`define SLA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: design/sla_pkg.sv
// ----------------------------------------------------------------------------
// sla_pkg
// Types and constants of the slot lease allocator.
// ----------------------------------------------------------------------------
package sla_pkg;

	localparam int SLOTS   = 16;
	localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SLOT_W  = 8;
	localparam int CNT_W   = 9;

	typedef enum logic [1:0] {
		MODE_ACQUIRE = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_CLOSE   = 2'd2,
		MODE_NOP     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_EMPTY   = 2'd1,
		STAT_CLOSING = 2'd2,
		STAT_BAD     = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_POP  = 1'b1
	} state_t;

endpackage

FILE: design/sla_ram.sv
// ----------------------------------------------------------------------------
// sla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/slot_lease_allocator_top.sv
// ----------------------------------------------------------------------------
// slot_lease_allocator_top
// Slot pool served from a LIFO free stack held in RAM, with lease bits,
// busy count and a closing flag.
// ----------------------------------------------------------------------------
//   channel | signals                                   | transfer when
//   --------+-------------------------------------------+-----------------------
//   in      | in_valid, in_ready, mode, slot            | in_valid & in_ready
//   out     | out_valid, out_ready, status,             | out_valid & out_ready
//           | granted_slot, busy_count, drained         |
//
// Release, close, no-op and refused acquire: result registered at the input
// transfer. A granted acquire first reads the stack top from the free-stack
// RAM (registered read data), then forms the result from that read.
// No clearing pass after reset: per-entry valid flops make an unwritten stack
// entry read as its own index. Input stalls while the result register is full
// and not being taken, and during the pop read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slot_lease_allocator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  mode,
	input  logic [sla_pkg::SLOT_W-1:0]  slot,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [sla_pkg::SLOT_W-1:0]  granted_slot,
	output logic [sla_pkg::CNT_W-1:0]   busy_count,
	output logic                        drained
);

	// control state
	sla_pkg::state_t            state_q, state_d;
	logic [sla_pkg::CNT_W-1:0]  free_q, free_d;
	logic [sla_pkg::CNT_W-1:0]  busy_q, busy_d;
	logic                       close_q, close_d;
	logic                       lease_q [sla_pkg::SLOTS];
	logic                       mvld_q [sla_pkg::SLOTS];   // stack entry written since reset
	logic                       out_valid_q;

	// pop read tracking
	logic [sla_pkg::IDX_W-1:0]  top_idx_s1;
	logic                       top_vld_s1;

	// result register
	logic [1:0]                 status_q;
	logic [sla_pkg::SLOT_W-1:0] granted_q;
	logic [sla_pkg::CNT_W-1:0]  busy_out_q;
	logic                       drained_q;

	// combinational controls
	logic                       accept;
	logic                       out_load;
	logic [1:0]                 status_d;
	logic [sla_pkg::SLOT_W-1:0] granted_d;
	logic                       ram_we, ram_re;
	logic [sla_pkg::IDX_W-1:0]  top_idx;
	logic [sla_pkg::IDX_W-1:0]  rel_idx;
	logic [sla_pkg::IDX_W-1:0]  push_idx;
	logic [sla_pkg::SLOT_W-1:0] ram_rdata;
	logic [sla_pkg::SLOT_W-1:0] pop_slot;
	logic [sla_pkg::IDX_W-1:0]  pop_idx;
	logic                       rel_ok;
	logic                       lease_set, lease_clr;

	assign top_idx  = sla_pkg::IDX_W'(free_q - sla_pkg::CNT_W'(1));
	assign push_idx = free_q[sla_pkg::IDX_W-1:0];
	assign rel_idx  = slot[sla_pkg::IDX_W-1:0];
	// unwritten entry holds its reset value, the index itself
	assign pop_slot = top_vld_s1 ? ram_rdata : sla_pkg::SLOT_W'(top_idx_s1);
	assign pop_idx  = pop_slot[sla_pkg::IDX_W-1:0];

	assign rel_ok = ({1'b0, slot} < sla_pkg::CNT_W'(sla_pkg::SLOTS))
		&& lease_q[rel_idx]
		&& (free_q < sla_pkg::CNT_W'(sla_pkg::SLOTS));

	sla_ram #(
		.WIDTH (sla_pkg::SLOT_W),
		.DEPTH (sla_pkg::SLOTS)
	) u_free_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (push_idx),
		.wdata (slot),
		.re    (ram_re),
		.raddr (top_idx),
		.rdata (ram_rdata)
	);

	// next state, datapath controls
	always_comb begin
		state_d   = state_q;
		free_d    = free_q;
		busy_d    = busy_q;
		close_d   = close_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		out_load  = 1'b0;
		status_d  = sla_pkg::STAT_OK;
		granted_d = '0;
		lease_set = 1'b0;
		lease_clr = 1'b0;
		in_ready  = (state_q == sla_pkg::ST_IDLE) && (!out_valid_q || out_ready);
		accept    = in_valid && in_ready;
		case (state_q)
			sla_pkg::ST_IDLE: begin
				if (accept) begin
					case (mode)
						sla_pkg::MODE_ACQUIRE: begin
							// closing wins over empty
							if (close_q) begin
								out_load = 1'b1;
								status_d = sla_pkg::STAT_CLOSING;
							end else if (free_q == '0) begin
								out_load = 1'b1;
								status_d = sla_pkg::STAT_EMPTY;
							end else begin
								ram_re  = 1'b1;
								state_d = sla_pkg::ST_POP;
							end
						end
						sla_pkg::MODE_RELEASE: begin
							out_load = 1'b1;
							if (rel_ok) begin
								ram_we    = 1'b1;
								lease_clr = 1'b1;
								free_d    = free_q + sla_pkg::CNT_W'(1);
								busy_d    = busy_q - sla_pkg::CNT_W'(1);
							end else begin
								status_d = sla_pkg::STAT_BAD;
							end
						end
						sla_pkg::MODE_CLOSE: begin
							out_load = 1'b1;
							close_d  = 1'b1;
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			sla_pkg::ST_POP: begin
				out_load  = 1'b1;
				lease_set = 1'b1;
				granted_d = pop_slot;
				free_d    = free_q - sla_pkg::CNT_W'(1);
				busy_d    = busy_q + sla_pkg::CNT_W'(1);
				state_d   = sla_pkg::ST_IDLE;
			end
			default: begin
				state_d = sla_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sla_pkg::ST_IDLE;
			free_q      <= sla_pkg::CNT_W'(sla_pkg::SLOTS);
			busy_q      <= '0;
			close_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < sla_pkg::SLOTS; i++) begin
				lease_q[i] <= 1'b0;
				mvld_q[i]  <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			free_q  <= free_d;
			busy_q  <= busy_d;
			close_q <= close_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				mvld_q[push_idx] <= 1'b1;
			end
			if (lease_clr) begin
				lease_q[rel_idx] <= 1'b0;
			end
			if (lease_set) begin
				lease_q[pop_idx] <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ram_re) begin
			top_idx_s1 <= top_idx;
			top_vld_s1 <= mvld_q[top_idx];
		end
		if (out_load) begin
			status_q   <= status_d;
			granted_q  <= granted_d;
			busy_out_q <= busy_d;
			drained_q  <= close_d && (busy_d == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign granted_slot = granted_q;
	assign busy_count   = busy_out_q;
	assign drained      = drained_q;

	// every slot is either on the free stack or leased
	`SLA_ASSERT_IMP(a_pool_conserved, 1'b1,
		(free_q + busy_q) == sla_pkg::CNT_W'(sla_pkg::SLOTS))
	// a grantable acquire always goes through the pop read
	`SLA_ASSERT_NXT(a_acq_pops, accept && (mode == sla_pkg::MODE_ACQUIRE) && !close_q
		&& (free_q != '0), (state_q == sla_pkg::ST_POP) && out_valid_q == 1'b0)
	// drained is only reported with nothing leased
	`SLA_ASSERT_IMP(a_drained_empty, out_valid_q && drained_q, busy_out_q == '0)
	// a nonzero grant only comes with an ok status
	`SLA_ASSERT_IMP(a_grant_ok, out_valid_q && (status_q != sla_pkg::STAT_OK),
		granted_q == '0)

endmodule

FILE: test/tb_slot_lease_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_slot_lease_allocator_top
// Self-checking bench for the slot lease allocator. A transfer-level copy of the
// pool (free stack, lease bits, busy count, closing flag) predicts one reply
// per input transfer. Directed corners come first, then weighted random
// traffic, then close and drain. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_slot_lease_allocator_top;

	localparam int CYCLE_LIMIT   = 400000;
	// Margin after the last booked reply, for stragglers.
	localparam int SETTLE_CYCLES = 10;

	// Every input is known from time zero.
	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic [1:0]                 mode      = sla_pkg::MODE_NOP;
	logic [sla_pkg::SLOT_W-1:0] slot      = '0;
	logic                       out_ready = 1'b0;

	logic                       in_ready;
	logic                       out_valid;
	logic [1:0]                 status;
	logic [sla_pkg::SLOT_W-1:0] granted_slot;
	logic [sla_pkg::CNT_W-1:0]  busy_count;
	logic                       drained;

	slot_lease_allocator_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.slot         (slot),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.granted_slot (granted_slot),
		.busy_count   (busy_count),
		.drained      (drained)
	);

	typedef struct packed {
		sla_pkg::status_t           status;
		logic [sla_pkg::SLOT_W-1:0] granted;
		logic [sla_pkg::CNT_W-1:0]  busy;
		logic                       drained;
	} pool_reply_t;

	// Replies owed by the block, oldest first.
	pool_reply_t pool_replies[$];

	// Shadow copy of the pool.
	logic [sla_pkg::SLOT_W-1:0] stack_m [sla_pkg::SLOTS];
	logic [sla_pkg::CNT_W-1:0]  free_m;
	logic [sla_pkg::CNT_W-1:0]  busy_m;
	logic [sla_pkg::SLOTS-1:0]  leased_m;
	logic                       closing_m;

	int errors = 0;
	int cycles = 0;
	int stall_left = 0;
	// When set, neither side idles.
	bit steady = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("slot_lease_allocator_top regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Pool shadow: applies one operation and returns the reply it implies.
	// Closing is tested before emptiness on acquire. A release needs an
	// in-range, leased slot and room on the stack, else nothing changes.
	// ------------------------------------------------------------------------
	function automatic pool_reply_t pool_step(sla_pkg::mode_t op,
		logic [sla_pkg::SLOT_W-1:0] s);
		pool_reply_t r;
		r.status  = sla_pkg::STAT_OK;
		r.granted = '0;
		case (op)
			sla_pkg::MODE_ACQUIRE: begin
				if (closing_m) begin
					r.status = sla_pkg::STAT_CLOSING;
				end else if (free_m == 0) begin
					r.status = sla_pkg::STAT_EMPTY;
				end else begin
					free_m             = free_m - 1'b1;
					r.granted          = stack_m[free_m];
					leased_m[r.granted] = 1'b1;
					busy_m             = busy_m + 1'b1;
				end
			end
			sla_pkg::MODE_RELEASE: begin
				if (s < sla_pkg::SLOTS && leased_m[s] && free_m < sla_pkg::SLOTS) begin
					leased_m[s]     = 1'b0;
					stack_m[free_m] = s;
					free_m          = free_m + 1'b1;
					busy_m          = busy_m - 1'b1;
				end else begin
					r.status = sla_pkg::STAT_BAD;
				end
			end
			sla_pkg::MODE_CLOSE: closing_m = 1'b1;
			default: ;
		endcase
		r.busy    = busy_m;
		r.drained = closing_m && (busy_m == 0);
		return r;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Random slot among those currently leased; any slot if none is.
	function automatic logic [sla_pkg::SLOT_W-1:0] pick_leased();
		int held[$];
		for (int i = 0; i < sla_pkg::SLOTS; i++)
			if (leased_m[i])
				held.push_back(i);
		if (held.size() == 0)
			return sla_pkg::SLOT_W'($urandom_range(0, 255));
		return sla_pkg::SLOT_W'(held[$urandom_range(0, held.size() - 1)]);
	endfunction

	// ------------------------------------------------------------------------
	// Sender: drive at the falling edge, hold until the transfer, then book
	// the expected reply. Valid stays high into the next item unless a gap
	// is drawn.
	// ------------------------------------------------------------------------
	task automatic send_item(sla_pkg::mode_t op, logic [sla_pkg::SLOT_W-1:0] s);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		mode     <= op;
		slot     <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pool_replies.push_back(pool_step(op, s));
		if (!steady && $urandom_range(0, 2) == 0) begin
			gap = idle_len();
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Sender holds off until every booked reply has come back.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pool_replies.size() != 0)
			@(posedge clk);
	endtask

	// Weighted mix: acquires and releases of held slots dominate so the pool
	// walks between empty and full; the rest is stray releases, no-ops and, if allowed, closes.
	task automatic send_random(int acq_pct, bit allow_close);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < acq_pct)
			send_item(sla_pkg::MODE_ACQUIRE, sla_pkg::SLOT_W'($urandom));
		else if (roll < 90)
			send_item(sla_pkg::MODE_RELEASE, pick_leased());
		else if (roll < 94)
			send_item(sla_pkg::MODE_RELEASE, sla_pkg::SLOT_W'($urandom_range(0, 255)));
		else if (roll < 97)
			send_item(sla_pkg::MODE_RELEASE,
				sla_pkg::SLOT_W'($urandom_range(0, sla_pkg::SLOTS - 1)));
		else if (roll < 99 || !allow_close)
			send_item(sla_pkg::MODE_NOP, sla_pkg::SLOT_W'($urandom));
		else
			send_item(sla_pkg::MODE_CLOSE, sla_pkg::SLOT_W'($urandom));
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Fresh pool: a no-op, then releases that must all be refused.
	task automatic test_idle_pool_corners();
		send_item(sla_pkg::MODE_NOP, 8'hFF);
		send_item(sla_pkg::MODE_RELEASE, sla_pkg::SLOT_W'(sla_pkg::SLOTS));
		send_item(sla_pkg::MODE_RELEASE, 8'hFF);
		send_item(sla_pkg::MODE_RELEASE, 8'h00);
		drain_results();
	endtask

	// Take every slot, hit the empty refusal, then double release.
	task automatic test_exhaust_pool();
		repeat (sla_pkg::SLOTS) send_item(sla_pkg::MODE_ACQUIRE, sla_pkg::SLOT_W'($urandom));
		send_item(sla_pkg::MODE_ACQUIRE, 8'h00);
		send_item(sla_pkg::MODE_RELEASE, sla_pkg::SLOT_W'(sla_pkg::SLOTS - 1));
		send_item(sla_pkg::MODE_RELEASE, sla_pkg::SLOT_W'(sla_pkg::SLOTS - 1));
		drain_results();
	endtask

	// Three segments: acquire heavy, release heavy with no idling, balanced.
	task automatic test_random_traffic();
		repeat (330) send_random(70, 1'b0);
		drain_results();
		steady = 1'b1;
		repeat (330) send_random(30, 1'b0);
		drain_results();
		steady = 1'b0;
		repeat (340) send_random(50, 1'b0);
		drain_results();
	endtask

	// Close with slots held: acquires refused, releases still honored until
	// the pool drains; then mixed traffic on the closed pool.
	task automatic test_close_and_drain();
		while (busy_m < 4)
			send_item(sla_pkg::MODE_ACQUIRE, sla_pkg::SLOT_W'($urandom));
		send_item(sla_pkg::MODE_CLOSE, 8'h00);
		send_item(sla_pkg::MODE_ACQUIRE, 8'h00);
		send_item(sla_pkg::MODE_CLOSE, 8'hFF);
		while (busy_m != 0)
			send_random(15, 1'b1);
		repeat (40) send_random(30, 1'b1);
		drain_results();
	endtask

	// ------------------------------------------------------------------------
	// Receiver: random stalls on out_ready, driven at the falling edge.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left != 0) begin
				out_ready  <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				out_ready <= 1'b1;
				if (!steady && $urandom_range(0, 3) == 0)
					stall_left <= idle_len();
			end
		end
	end

	// Reply checker: each output transfer against the oldest booked reply.
	always @(posedge clk) begin : check_replies
		pool_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pool_replies.size() == 0) begin
				$error("reply with nothing pending: status=%0d granted_slot=%0d",
					status, granted_slot);
				errors++;
			end else begin
				want = pool_replies.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (granted_slot !== want.granted) begin
					$error("granted_slot: expected %0d, got %0d", want.granted,
						granted_slot);
					errors++;
				end
				if (busy_count !== want.busy) begin
					$error("busy_count: expected %0d, got %0d", want.busy, busy_count);
					errors++;
				end
				if (drained !== want.drained) begin
					$error("drained: expected %0d, got %0d", want.drained, drained);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		// Shadow pool at reset: entry i holds i, all free.
		for (int i = 0; i < sla_pkg::SLOTS; i++)
			stack_m[i] = sla_pkg::SLOT_W'(i);
		free_m    = sla_pkg::CNT_W'(sla_pkg::SLOTS);
		busy_m    = '0;
		leased_m  = '0;
		closing_m = 1'b0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_idle_pool_corners();
		test_exhaust_pool();
		test_random_traffic();
		test_close_and_drain();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pool_replies.size() == 0)
			$display("slot_lease_allocator_top regression: pass");
		else
			$display("slot_lease_allocator_top regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/sla_pkg.sv
design/sla_ram.sv
design/slot_lease_allocator_top.sv
test/tb_slot_lease_allocator_top.sv
